>>> design/chained_hash_map_unit_macros.svh
// ----------------------------------------------------------------------------
// chained hash map assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef CHAINED_HASH_MAP_UNIT_MACROS_SVH
`define CHAINED_HASH_MAP_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define CHM_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define CHM_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/chm_pkg.sv
// ----------------------------------------------------------------------------
// chm_pkg
// types and codes shared by the chained hash map
// ----------------------------------------------------------------------------
package chm_pkg;

  localparam int KEY_W  = 20;
  localparam int VAL_W  = 20;

  typedef enum logic [1:0] {
    OP_PUT    = 2'd0,
    OP_GET    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } stat_t;

  typedef struct packed {
    op_t              operation;
    logic [KEY_W-1:0] lookup_key;
    logic [VAL_W-1:0] store_value;
  } req_t;

  typedef struct packed {
    stat_t            status;
    logic [VAL_W-1:0] found_value;
  } rsp_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_HEAD,
    S_NODE,
    S_REM2,
    S_MISS,
    S_ALLOC
  } state_t;

endpackage

>>> design/chm_ram.sv
// ----------------------------------------------------------------------------
// chm_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module chm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/chm_mod.sv
// ----------------------------------------------------------------------------
// chm_mod
// key modulo bucket count by reciprocal multiplication, registered as key, quotient, remainder
// ----------------------------------------------------------------------------
module chm_mod #(
  parameter int BUCKETS = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       go,
  input  logic [chm_pkg::KEY_W-1:0]  value,
  output logic                       done,
  output logic [$clog2(BUCKETS)-1:0] rem
);
  import chm_pkg::*;

  // quotient = (key * ceil(2^SH / BUCKETS)) >> SH is exact for every key
  localparam int BW = $clog2(BUCKETS);
  localparam int SH = KEY_W + BW;
  localparam int MW = KEY_W + 2;
  localparam int PW = KEY_W + MW;
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

  logic             s1;
  logic             s2;
  logic [KEY_W-1:0] k;
  logic [KEY_W-1:0] q;
  logic [PW-1:0]    prod;
  logic [KEY_W-1:0] qd;
  logic [BW-1:0]    r;

  always_comb begin
    prod = PW'(k) * PW'(RECIP);
    qd   = q * KEY_W'(BUCKETS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1   <= 1'b0;
      s2   <= 1'b0;
      done <= 1'b0;
    end else begin
      s1   <= go;
      s2   <= s1;
      done <= s2;
    end
  end

  // key, quotient, remainder
  always_ff @(posedge clk) begin
    if (go) begin
      k <= value;
    end
    if (s1) begin
      q <= KEY_W'(prod >> SH);
    end
    if (s2) begin
      r <= BW'(k - qd);
    end
  end

  assign rem = r;

endmodule

>>> design/chained_hash_map_unit.sv
// ----------------------------------------------------------------------------
// chained_hash_map_unit
// key/value map: hash table with separate chaining over a fixed node pool
// ----------------------------------------------------------------------------
//  channel   | ports                     | handshake
//  request   | start, busy, request      | taken when start and not busy
//  response  | done, response            | one-cycle strobe, cannot stall
//
//  the result strobe follows the reciprocal modulo, the bucket head read and
//  the chain walk, which reads one node a cycle; a miss or a remove hit
//  adds the miss or the free-list state, and a put that reuses a freed node
//  adds both the miss and the alloc states
//  after reset every bucket head is cleared to empty while busy is high
//  results cannot be held off; busy drops with the result strobe
// ----------------------------------------------------------------------------
module chained_hash_map_unit #(
  parameter int BUCKETS    = 1024,
  parameter int POOL_NODES = 1024,
  parameter int KEY_BITS   = 20
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  chm_pkg::req_t request,
  output logic          done,
  output chm_pkg::rsp_t response
);
  import chm_pkg::*;

  // widths: bucket index, node address, link (0 means none, n means node n-1)
  localparam int BW = $clog2(BUCKETS);
  localparam int NW = $clog2(POOL_NODES);
  localparam int LW = $clog2(POOL_NODES + 1);
  localparam int WW = KEY_W + VAL_W + LW;
  localparam logic [KEY_W-1:0] KEY_MASK = (KEY_BITS >= KEY_W) ? {KEY_W{1'b1}} :
                                          KEY_W'((64'd1 << KEY_BITS) - 64'd1);

  state_t        state, state_next;
  req_t          req, req_next;
  logic [BW-1:0] bkt, bkt_next;
  logic [LW-1:0] cur, cur_next;
  logic [LW-1:0] prev, prev_next;
  logic [WW-1:0] prev_word, prev_word_next;
  logic [WW-1:0] cur_word, cur_word_next;
  logic [LW-1:0] head, head_next;
  logic [LW-1:0] free_head, free_head_next;
  logic [LW-1:0] fresh, fresh_next;
  logic [BW-1:0] clr_cnt, clr_cnt_next;
  logic          done_next;
  rsp_t          rsp_next;

  // bucket head ram ports
  logic          bh_we;
  logic [BW-1:0] bh_waddr, bh_raddr;
  logic [LW-1:0] bh_wdata, bh_rdata;

  // node ram ports: word is {key, value, link}
  logic          nd_we;
  logic [NW-1:0] nd_waddr, nd_raddr;
  logic [WW-1:0] nd_wdata, nd_rdata;

  logic          mod_go, mod_done;
  logic [BW-1:0] mod_rem;

  logic [KEY_W-1:0] rd_key;
  logic [LW-1:0]    rd_link;
  logic [VAL_W-1:0] rd_val;
  logic [LW-1:0]    cur_m1, link_m1, prev_m1, free_m1;

  chm_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_heads (
    .clk(clk), .we(bh_we), .waddr(bh_waddr), .wdata(bh_wdata),
    .raddr(bh_raddr), .rdata(bh_rdata)
  );

  chm_ram #(.WIDTH(WW), .DEPTH(POOL_NODES)) u_nodes (
    .clk(clk), .we(nd_we), .waddr(nd_waddr), .wdata(nd_wdata),
    .raddr(nd_raddr), .rdata(nd_rdata)
  );

  // the modulo takes the masked key straight from the request port
  chm_mod #(.BUCKETS(BUCKETS)) u_mod (
    .clk(clk), .rst(rst), .go(mod_go), .value(request.lookup_key & KEY_MASK),
    .done(mod_done), .rem(mod_rem)
  );

  // fields of the node word just read
  assign rd_link = nd_rdata[LW-1:0];
  assign rd_val  = nd_rdata[LW+VAL_W-1:LW];
  assign rd_key  = nd_rdata[WW-1:LW+VAL_W];

  // link to ram address
  assign cur_m1  = cur - LW'(1);
  assign link_m1 = rd_link - LW'(1);
  assign prev_m1 = prev - LW'(1);
  assign free_m1 = free_head - LW'(1);

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      free_head <= '0;
      fresh     <= '0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      clr_cnt   <= clr_cnt_next;
      free_head <= free_head_next;
      fresh     <= fresh_next;
      done      <= done_next;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    req       <= req_next;
    bkt       <= bkt_next;
    cur       <= cur_next;
    prev      <= prev_next;
    prev_word <= prev_word_next;
    cur_word  <= cur_word_next;
    head      <= head_next;
    response  <= rsp_next;
  end

  always_comb begin
    state_next     = state;
    req_next       = req;
    bkt_next       = bkt;
    cur_next       = cur;
    prev_next      = prev;
    prev_word_next = prev_word;
    cur_word_next  = cur_word;
    head_next      = head;
    free_head_next = free_head;
    fresh_next     = fresh;
    clr_cnt_next   = clr_cnt;
    done_next      = 1'b0;
    rsp_next       = response;
    mod_go         = 1'b0;
    bh_we          = 1'b0;
    bh_waddr       = bkt;
    bh_wdata       = '0;
    bh_raddr       = mod_rem;
    nd_we          = 1'b0;
    nd_waddr       = cur_m1[NW-1:0];
    nd_wdata       = '0;
    nd_raddr       = link_m1[NW-1:0];

    unique case (state)
      // clearing pass over the bucket heads
      S_CLEAR: begin
        bh_we        = 1'b1;
        bh_waddr     = clr_cnt;
        bh_wdata     = '0;
        clr_cnt_next = clr_cnt + 1'b1;
        if (clr_cnt == BW'(BUCKETS - 1)) begin
          state_next = S_IDLE;
        end
      end

      // take a request, mask the key to the used bits
      S_IDLE: begin
        if (start) begin
          req_next            = request;
          req_next.lookup_key = request.lookup_key & KEY_MASK;
          mod_go              = 1'b1;
          state_next          = S_MOD;
        end
      end

      // wait for the bucket index, then read its head
      S_MOD: begin
        if (mod_done) begin
          bkt_next   = mod_rem;
          bh_raddr   = mod_rem;
          state_next = S_HEAD;
        end
      end

      // head link available
      S_HEAD: begin
        head_next = bh_rdata;
        cur_next  = bh_rdata;
        prev_next = '0;
        if (req.operation == OP_NONE) begin
          done_next   = 1'b1;
          rsp_next    = '{status: ST_OK, found_value: '0};
          state_next  = S_IDLE;
        end else if (bh_rdata == '0) begin
          state_next = S_MISS;
        end else begin
          nd_raddr   = NW'(bh_rdata - LW'(1));
          state_next = S_NODE;
        end
      end

      // chain walk, one node per cycle
      S_NODE: begin
        if (rd_key == req.lookup_key) begin
          case (req.operation)
            OP_PUT: begin
              nd_we      = 1'b1;
              nd_waddr   = cur_m1[NW-1:0];
              nd_wdata   = {rd_key, req.store_value, rd_link};
              done_next  = 1'b1;
              rsp_next   = '{status: ST_OK, found_value: '0};
              state_next = S_IDLE;
            end
            OP_GET: begin
              done_next  = 1'b1;
              rsp_next   = '{status: ST_OK, found_value: rd_val};
              state_next = S_IDLE;
            end
            OP_REMOVE: begin
              // unlink: patch the bucket head or the previous node
              if (prev == '0) begin
                bh_we    = 1'b1;
                bh_waddr = bkt;
                bh_wdata = rd_link;
              end else begin
                nd_we    = 1'b1;
                nd_waddr = prev_m1[NW-1:0];
                nd_wdata = {prev_word[WW-1:LW], rd_link};
              end
              cur_word_next = nd_rdata;
              state_next    = S_REM2;
            end
            default: begin
              done_next  = 1'b1;
              rsp_next   = '{status: ST_OK, found_value: '0};
              state_next = S_IDLE;
            end
          endcase
        end else begin
          prev_next      = cur;
          prev_word_next = nd_rdata;
          cur_next       = rd_link;
          if (rd_link == '0) begin
            state_next = S_MISS;
          end else begin
            nd_raddr = link_m1[NW-1:0];
          end
        end
      end

      // push the removed node on the free list
      S_REM2: begin
        nd_we          = 1'b1;
        nd_waddr       = cur_m1[NW-1:0];
        nd_wdata       = {cur_word[WW-1:LW], free_head};
        free_head_next = cur;
        done_next      = 1'b1;
        rsp_next       = '{status: ST_OK, found_value: '0};
        state_next     = S_IDLE;
      end

      // key absent: put allocates or reports full, others report not found
      S_MISS: begin
        if (req.operation != OP_PUT) begin
          done_next  = 1'b1;
          rsp_next   = '{status: ST_NOT_FOUND, found_value: '0};
          state_next = S_IDLE;
        end else if (free_head != '0) begin
          nd_raddr   = free_m1[NW-1:0];
          state_next = S_ALLOC;
        end else if (fresh != LW'(POOL_NODES)) begin
          fresh_next = fresh + 1'b1;
          nd_we      = 1'b1;
          nd_waddr   = fresh[NW-1:0];
          nd_wdata   = {req.lookup_key, req.store_value, head};
          bh_we      = 1'b1;
          bh_waddr   = bkt;
          bh_wdata   = fresh + 1'b1;
          done_next  = 1'b1;
          rsp_next   = '{status: ST_OK, found_value: '0};
          state_next = S_IDLE;
        end else begin
          done_next  = 1'b1;
          rsp_next   = '{status: ST_FULL, found_value: '0};
          state_next = S_IDLE;
        end
      end

      // reuse the first freed node and prepend it
      S_ALLOC: begin
        free_head_next = rd_link;
        nd_we          = 1'b1;
        nd_waddr       = free_m1[NW-1:0];
        nd_wdata       = {req.lookup_key, req.store_value, head};
        bh_we          = 1'b1;
        bh_waddr       = bkt;
        bh_wdata       = free_head;
        done_next      = 1'b1;
        rsp_next       = '{status: ST_OK, found_value: '0};
        state_next     = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> design/chm_check.sv
// ----------------------------------------------------------------------------
// chm_check
// port-level checks on the chained hash map
// ----------------------------------------------------------------------------
`include "chained_hash_map_unit_macros.svh"

module chm_check (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input chm_pkg::req_t request,
  input logic          done,
  input chm_pkg::rsp_t response
);
  import chm_pkg::*;

  `CHM_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "no busy after request")
  `CHM_ASSERT_NOW(a_done_idle, clk, rst, done, !busy, "result while busy")
  `CHM_ASSERT_NEXT(a_done_single, clk, rst, done, !done, "result strobe longer than a cycle")
  `CHM_ASSERT_NOW(a_value_zero, clk, rst, done && response.status != ST_OK,
                  response.found_value == '0, "value on a failed request")

endmodule

bind chained_hash_map_unit chm_check u_chm_check (.*);
